[rtl/core/mrdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal interlock package
// Shared widths, codes and item types for the H-bridge reversal interlock.
// ----------------------------------------------------------------------------
package mrdt_pkg;

  localparam int OP_W     = 3;
  localparam int DIR_W    = 2;
  localparam int DUTY_W   = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Operation codes as they arrive on the event channel.
  localparam logic [OP_W-1:0] OP_COMMAND  = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE   = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
  localparam logic [OP_W-1:0] OP_INIT     = 3'd3;
  localparam logic [OP_W-1:0] OP_SHUTDOWN = 3'd4;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = 1'b1;

  // Largest forward time step and largest valid dead time.
  localparam logic [TIME_W-1:0] MAX_FORWARD = 32'h7FFF_FFFF;

  localparam logic [TIME_W-1:0] DEAD_TIME_RESET = 32'd100;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RESET  = 8'd255;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOINIT = 2'd1,
    ST_INVAL  = 2'd2,
    ST_HWFAIL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_RUNNING  = 2'd1,
    PH_WAITING  = 2'd2,
    PH_FAULT    = 2'd3
  } phase_t;

  // Event class decided by the front end.
  typedef enum logic [2:0] {
    KIND_COMMAND  = 3'd0,
    KIND_UPDATE   = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_INIT     = 3'd3,
    KIND_SHUTDOWN = 3'd4,
    KIND_INVALID  = 3'd5
  } kind_t;

  // One classified event waiting in the queue.
  typedef struct packed {
    kind_t               kind;
    logic                cmd_ok;
    logic                cfg_ok;
    logic [DIR_W-1:0]    direction;
    logic [DUTY_W-1:0]   duty;
    logic [TIME_W-1:0]   now_ms;
    logic                power_admitted;
  } work_t;

  // One result snapshot, without the derived deadline.
  typedef struct packed {
    status_t             status;
    phase_t              phase;
    logic [DIR_W-1:0]    applied_direction;
    logic [DUTY_W-1:0]   applied_duty;
    logic [DIR_W-1:0]    requested_direction;
    logic [DUTY_W-1:0]   requested_duty;
    logic [TIME_W-1:0]   phase_since_ms;
    logic                has_deadline;
    logic [TIME_W-1:0]   transition_count;
    logic                is_initialized;
  } result_t;

endpackage

[rtl/core/mrdt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal interlock channels
// Valid/ready channels for events, results and configuration writes.
// ----------------------------------------------------------------------------

// Event channel: one motor intent event per transfer.
interface mrdt_event_if import mrdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [DIR_W-1:0]    direction;
  logic [DUTY_W-1:0]   duty;
  logic [TIME_W-1:0]   now_ms;
  logic                power_admitted;

  modport source (output valid, operation, direction, duty, now_ms, power_admitted,
                  input ready);
  modport sink   (input valid, operation, direction, duty, now_ms, power_admitted,
                  output ready);
endinterface

// Result channel: one status and snapshot per transfer.
interface mrdt_result_if import mrdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [1:0]          phase;
  logic [DIR_W-1:0]    applied_direction;
  logic [DUTY_W-1:0]   applied_duty;
  logic [DIR_W-1:0]    requested_direction;
  logic [DUTY_W-1:0]   requested_duty;
  logic [TIME_W-1:0]   phase_since_ms;
  logic [TIME_W-1:0]   next_deadline_ms;
  logic                has_deadline;
  logic [TIME_W-1:0]   transition_count;
  logic                is_initialized;

  modport source (output valid, status, phase, applied_direction, applied_duty,
                  requested_direction, requested_duty, phase_since_ms,
                  next_deadline_ms, has_deadline, transition_count, is_initialized,
                  input ready);
  modport sink   (input valid, status, phase, applied_direction, applied_duty,
                  requested_direction, requested_duty, phase_since_ms,
                  next_deadline_ms, has_deadline, transition_count, is_initialized,
                  output ready);
endinterface

// Configuration write channel.
interface mrdt_cfg_if import mrdt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/mrdt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal interlock front end
// Accepts events, decodes the operation and checks arguments and
// configuration, then pushes the classified event into the queue.
// ----------------------------------------------------------------------------
module mrdt_front import mrdt_pkg::*; (
  mrdt_event_if.sink          events,
  input  logic [TIME_W-1:0]   dead_time_ms,
  input  logic [DUTY_W-1:0]   maximum_duty,
  input  logic                push_ready,
  output logic                push_valid,
  output work_t               push_item
);

  kind_t kind;
  logic  cmd_ok;
  logic  cfg_ok;

  // Operation decode; unused codes become an invalid event.
  always_comb begin
    case (events.operation)
      OP_COMMAND:  kind = KIND_COMMAND;
      OP_UPDATE:   kind = KIND_UPDATE;
      OP_STOP:     kind = KIND_STOP;
      OP_INIT:     kind = KIND_INIT;
      OP_SHUTDOWN: kind = KIND_SHUTDOWN;
      default:     kind = KIND_INVALID;
    endcase
  end

  // A stop command carries zero duty; a drive command carries a duty in range.
  always_comb begin
    if (events.direction == DIR_STOP) begin
      cmd_ok = (events.duty == '0);
    end else begin
      cmd_ok = (events.direction == DIR_FWD || events.direction == DIR_REV) &&
               (events.duty != '0) && (events.duty <= maximum_duty);
    end
  end

  // Configuration check used by initialize.
  assign cfg_ok = (dead_time_ms != '0) && (dead_time_ms <= MAX_FORWARD) &&
                  (maximum_duty != '0);

  // Transfers pass straight into the queue.
  assign events.ready = push_ready;
  assign push_valid   = events.valid;

  always_comb begin
    push_item.kind           = kind;
    push_item.cmd_ok         = cmd_ok;
    push_item.cfg_ok         = cfg_ok;
    push_item.direction      = events.direction;
    push_item.duty           = events.duty;
    push_item.now_ms         = events.now_ms;
    push_item.power_admitted = events.power_admitted;
  end

endmodule

[rtl/core/mrdt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal interlock queue
// Small FIFO of classified events between the front end and the back end.
// DEPTH is at least 2.
// ----------------------------------------------------------------------------
module mrdt_queue import mrdt_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  input  work_t  push_item,
  output logic   push_ready,
  output logic   pop_valid,
  output work_t  pop_item,
  input  logic   pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  work_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/core/mrdt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal interlock back end
// Runs one classified event per cycle on the interlock state while the output
// register is free or emptied, and loads the status and snapshot into it.
// ----------------------------------------------------------------------------
module mrdt_back import mrdt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [TIME_W-1:0]  dead_time_ms,
  input  logic               item_valid,
  input  work_t              item,
  output logic               pop,
  output logic               res_valid,
  output result_t            res,
  input  logic               res_ready
);

  typedef struct packed {
    logic              init_flag;
    logic              last_update_valid;
    logic [TIME_W-1:0] last_update_time;
    phase_t            phase;
    logic [TIME_W-1:0] phase_start;
    logic [DIR_W-1:0]  req_dir;
    logic [DUTY_W-1:0] req_duty;
    logic [DIR_W-1:0]  drive_dir;
    logic [DUTY_W-1:0] drive_duty;
    logic [DIR_W-1:0]  dir_before_wait;
    logic              deadline_pending;
    logic [TIME_W-1:0] transitions;
    status_t           sticky;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    init_flag:         1'b0,
    last_update_valid: 1'b0,
    last_update_time:  '0,
    phase:             PH_INACTIVE,
    phase_start:       '0,
    req_dir:           DIR_STOP,
    req_duty:          '0,
    drive_dir:         DIR_STOP,
    drive_duty:        '0,
    dir_before_wait:   DIR_STOP,
    deadline_pending:  1'b0,
    transitions:       '0,
    sticky:            ST_OK
  };

  state_t            s;
  state_t            s_next;
  status_t           st;
  logic [TIME_W-1:0] update_gap;
  logic [TIME_W-1:0] wait_gap;
  logic              time_ok;
  logic              dead_done;
  logic              do_fault;
  status_t           fault_code;
  logic              do_drive;
  logic [DIR_W-1:0]  drv_dir;
  logic [DUTY_W-1:0] drv_duty;
  phase_t            drv_phase;
  logic              do_wait;

  // Wrapping time distances.
  assign update_gap = item.now_ms - s.last_update_time;
  assign wait_gap   = item.now_ms - s.phase_start;
  assign time_ok    = !s.last_update_valid || (update_gap <= MAX_FORWARD);
  assign dead_done  = (wait_gap >= dead_time_ms);

  // Event decision: pick the action, then apply it to the state.
  always_comb begin
    s_next     = s;
    st         = ST_OK;
    do_fault   = 1'b0;
    fault_code = ST_OK;
    do_drive   = 1'b0;
    drv_dir    = DIR_STOP;
    drv_duty   = '0;
    drv_phase  = PH_RUNNING;
    do_wait    = 1'b0;

    case (item.kind)
      KIND_COMMAND: begin
        if (!s.init_flag) begin
          st = ST_NOINIT;
        end else if (s.sticky != ST_OK) begin
          st = s.sticky;
        end else if (!item.cmd_ok) begin
          st = ST_INVAL;
        end else if (!time_ok) begin
          do_fault   = 1'b1;
          fault_code = ST_INVAL;
        end else begin
          s_next.last_update_time  = item.now_ms;
          s_next.last_update_valid = 1'b1;
          s_next.req_dir           = item.direction;
          s_next.req_duty          = item.duty;
          if (item.direction == DIR_STOP) begin
            do_drive  = 1'b1;
            drv_phase = PH_INACTIVE;
          end else if (!item.power_admitted) begin
            do_fault   = 1'b1;
            fault_code = ST_HWFAIL;
          end else if (s.phase == PH_WAITING) begin
            // Only a return to the pre-wait direction cancels the dead time.
            if (item.direction == s.dir_before_wait) begin
              do_drive = 1'b1;
              drv_dir  = item.direction;
              drv_duty = item.duty;
            end
          end else if (s.drive_dir == DIR_STOP || s.drive_dir == item.direction) begin
            do_drive = 1'b1;
            drv_dir  = item.direction;
            drv_duty = item.duty;
          end else begin
            do_wait = 1'b1;
          end
        end
      end
      KIND_UPDATE: begin
        if (!s.init_flag) begin
          st = ST_NOINIT;
        end else if (s.sticky != ST_OK) begin
          st = s.sticky;
        end else if (!time_ok) begin
          do_fault   = 1'b1;
          fault_code = ST_INVAL;
        end else begin
          s_next.last_update_time  = item.now_ms;
          s_next.last_update_valid = 1'b1;
          if ((s.phase == PH_RUNNING || s.phase == PH_WAITING) &&
              !item.power_admitted) begin
            do_fault   = 1'b1;
            fault_code = ST_HWFAIL;
          end else if (s.phase == PH_WAITING && dead_done) begin
            do_drive = 1'b1;
            drv_dir  = s.req_dir;
            drv_duty = s.req_duty;
          end
        end
      end
      KIND_STOP: begin
        if (!s.init_flag) begin
          st = ST_NOINIT;
        end else begin
          s_next.req_dir          = DIR_STOP;
          s_next.req_duty         = '0;
          s_next.drive_dir        = DIR_STOP;
          s_next.drive_duty       = '0;
          s_next.deadline_pending = 1'b0;
          if (s.phase == PH_RUNNING || s.phase == PH_WAITING) begin
            s_next.phase       = PH_INACTIVE;
            s_next.transitions = s.transitions + 1'b1;
          end
          st = s.sticky;
        end
      end
      KIND_INIT: begin
        if (s.init_flag) begin
          st = s.sticky;
        end else if (!item.cfg_ok) begin
          s_next.sticky = ST_INVAL;
          st            = ST_INVAL;
        end else begin
          s_next           = STATE_CLEAR;
          s_next.init_flag = 1'b1;
        end
      end
      KIND_SHUTDOWN: begin
        s_next = STATE_CLEAR;
      end
      default: begin
        st = ST_INVAL;
      end
    endcase

    // Reversal: clear the drive and start the dead time.
    if (do_wait) begin
      s_next.dir_before_wait  = s.drive_dir;
      s_next.drive_dir        = DIR_STOP;
      s_next.drive_duty       = '0;
      s_next.phase            = PH_WAITING;
      s_next.phase_start      = item.now_ms;
      s_next.deadline_pending = 1'b1;
      s_next.transitions      = s.transitions + 1'b1;
    end

    // Apply a drive; a phase change restarts the phase clock.
    if (do_drive) begin
      s_next.drive_dir        = drv_dir;
      s_next.drive_duty       = drv_duty;
      s_next.dir_before_wait  = DIR_STOP;
      s_next.phase            = drv_phase;
      s_next.deadline_pending = 1'b0;
      if (s.phase != drv_phase) begin
        s_next.phase_start = item.now_ms;
        s_next.transitions = s.transitions + 1'b1;
      end
    end

    // Latch a fault with its sticky code.
    if (do_fault) begin
      s_next.drive_dir        = DIR_STOP;
      s_next.drive_duty       = '0;
      s_next.phase            = PH_FAULT;
      s_next.sticky           = fault_code;
      s_next.phase_start      = item.now_ms;
      s_next.deadline_pending = 1'b0;
      s_next.transitions      = s.transitions + 1'b1;
      st                      = fault_code;
    end
  end

  // An event executes when the output register is free or being emptied.
  assign pop = item_valid && (!res_valid || res_ready);

  // Interlock state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s <= STATE_CLEAR;
    end else if (pop) begin
      s <= s_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.status              <= st;
      res.phase               <= s_next.phase;
      res.applied_direction   <= s_next.drive_dir;
      res.applied_duty        <= s_next.drive_duty;
      res.requested_direction <= s_next.req_dir;
      res.requested_duty      <= s_next.req_duty;
      res.phase_since_ms      <= s_next.phase_start;
      res.has_deadline        <= s_next.deadline_pending;
      res.transition_count    <= s_next.transitions;
      res.is_initialized      <= s_next.init_flag;
    end
  end

endmodule

[rtl/core/motor_reversal_dead_time_interlock.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal dead-time interlock
// H-bridge interlock that tracks requested and applied drive, inserts a
// dead time on direction reversal and latches faults.
// ----------------------------------------------------------------------------
// Usage:
// Events (command, update, stop, initialize, shutdown) enter on the events
// channel; each transfer produces exactly one transfer on the results
// channel carrying the status and a snapshot of the interlock state.
// The cfg channel writes dead_time_ms (index 0) and maximum_duty (index 1);
// it is always ready; the user must write it only while no event is in flight,
// as the block itself does not enforce this. An accepted event is written into
// the queue, then executed by the back end, and its result is loaded into the
// output register for the results channel. Throughput is one event per cycle
// while the results channel is not stalled.
// When the receiver stalls, the result holds in the output register and the
// queue (QUEUE_DEPTH entries) keeps accepting events until it fills.
// Reset clears the interlock state, restores the configuration defaults
// (dead time 100 ms, maximum duty 255) and empties the queue.
// ----------------------------------------------------------------------------
module motor_reversal_dead_time_interlock import mrdt_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  mrdt_event_if.sink     events,
  mrdt_result_if.source  results,
  mrdt_cfg_if.sink       cfg
);

  logic [TIME_W-1:0] dead_time_ms;
  logic [DUTY_W-1:0] maximum_duty;

  logic    push_valid;
  logic    push_ready;
  work_t   push_item;
  logic    q_valid;
  work_t   q_item;
  logic    q_pop;
  logic    res_valid;
  result_t res;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_time_ms <= DEAD_TIME_RESET;
      maximum_duty <= MAX_DUTY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DEAD_TIME: dead_time_ms <= cfg.data;
        CFG_MAX_DUTY:  maximum_duty <= cfg.data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mrdt_front u_front (
    .events       (events),
    .dead_time_ms (dead_time_ms),
    .maximum_duty (maximum_duty),
    .push_ready   (push_ready),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  mrdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  mrdt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .dead_time_ms (dead_time_ms),
    .item_valid   (q_valid),
    .item         (q_item),
    .pop          (q_pop),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (results.ready)
  );

  // Result channel; the deadline is derived from the phase start.
  assign results.valid               = res_valid;
  assign results.status              = res.status;
  assign results.phase               = res.phase;
  assign results.applied_direction   = res.applied_direction;
  assign results.applied_duty        = res.applied_duty;
  assign results.requested_direction = res.requested_direction;
  assign results.requested_duty      = res.requested_duty;
  assign results.phase_since_ms      = res.phase_since_ms;
  assign results.next_deadline_ms    = res.phase_since_ms + dead_time_ms;
  assign results.has_deadline        = res.has_deadline;
  assign results.transition_count    = res.transition_count;
  assign results.is_initialized      = res.is_initialized;

endmodule

[rtl/core/mrdt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal interlock checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mrdt_checker import mrdt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               ready,
  input logic [1:0]         status,
  input logic [1:0]         phase,
  input logic [DIR_W-1:0]   applied_direction,
  input logic [DUTY_W-1:0]  applied_duty,
  input logic               has_deadline,
  input logic [TIME_W-1:0]  transition_count,
  input logic               is_initialized
);

  // A stalled result keeps its valid, its status and its transition count.
  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(status) && $stable(transition_count))
    else $error("result changed while stalled");

  // A pending deadline only exists while waiting for the dead time.
  assert property (@(posedge clk) disable iff (rst)
    valid && has_deadline |-> phase == PH_WAITING)
    else $error("deadline outside of dead time wait");

  // No drive while waiting for the dead time or in fault.
  assert property (@(posedge clk) disable iff (rst)
    valid && (phase == PH_WAITING || phase == PH_FAULT) |->
      applied_direction == DIR_STOP && applied_duty == '0)
    else $error("drive applied during dead time or fault");

  // An uninitialized interlock is inactive with a cleared history.
  assert property (@(posedge clk) disable iff (rst)
    valid && !is_initialized |->
      phase == PH_INACTIVE && transition_count == '0 && applied_direction == DIR_STOP)
    else $error("state present while not initialized");

endmodule

bind motor_reversal_dead_time_interlock mrdt_checker u_mrdt_checker (
  .clk               (clk),
  .rst               (rst),
  .valid             (results.valid),
  .ready             (results.ready),
  .status            (results.status),
  .phase             (results.phase),
  .applied_direction (results.applied_direction),
  .applied_duty      (results.applied_duty),
  .has_deadline      (results.has_deadline),
  .transition_count  (results.transition_count),
  .is_initialized    (results.is_initialized)
);
